// File: hdl/sort_with_extreme_counts_unit_macros.svh
// Assertion macros for the sort_with_extreme_counts_unit project.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SORT_WITH_EXTREME_COUNTS_UNIT_MACROS_SVH
`define SORT_WITH_EXTREME_COUNTS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define SWEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SWEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SWEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SWEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/swec_pkg.sv
// Shared types and constants for sort_with_extreme_counts_unit.
// No dependencies.
`timescale 1ns / 1ps
package swec_pkg;
	localparam int DIG_W         = 4;
	localparam int VAL_W         = 6;
	localparam int SUM_W         = 12;
	localparam int STAT_CNT_W    = 7;
	localparam int BINS          = 1 << VAL_W;
	localparam int MAX_ITEMS_DEF = 64;
	localparam logic [STAT_CNT_W-1:0] COUNT_CAP = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_FLUSH,
		ST_READ,
		ST_TAKE,
		ST_EMIT
	} swec_state_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]   sum;
		logic signed [VAL_W-1:0]   max_val;
		logic [STAT_CNT_W-1:0]     max_cnt;
		logic signed [VAL_W-1:0]   min_val;
		logic [STAT_CNT_W-1:0]     min_cnt;
	} swec_stats_t;
endpackage

// File: hdl/swec_hist_ram.sv
// Histogram memory: one count per value code, one write and one read port.
// Read data is registered. Depends on swec_pkg.
`timescale 1ns / 1ps
module swec_hist_ram #(
	parameter int MAX_ITEMS = swec_pkg::MAX_ITEMS_DEF
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [swec_pkg::VAL_W-1:0]       wr_addr,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]   wr_data,
	input  logic                             rd_en,
	input  logic [swec_pkg::VAL_W-1:0]       rd_addr,
	output logic [$clog2(MAX_ITEMS+1)-1:0]   rd_data
);
	import swec_pkg::*;

	localparam int HCNT_W = $clog2(MAX_ITEMS+1);

	logic [HCNT_W-1:0] mem [BINS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: hdl/swec_stats.sv
// Running sum, maximum and minimum with saturating occurrence counts.
// Depends on swec_pkg.
`timescale 1ns / 1ps
module swec_stats (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               upd,
	input  logic                               first,
	input  logic                               clr,
	input  logic signed [swec_pkg::VAL_W-1:0]  val,
	output swec_pkg::swec_stats_t              stats
);
	import swec_pkg::*;

	logic signed [SUM_W-1:0]   sum_q;
	logic signed [VAL_W-1:0]   max_q;
	logic [STAT_CNT_W-1:0]     maxc_q;
	logic signed [VAL_W-1:0]   min_q;
	logic [STAT_CNT_W-1:0]     minc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			max_q  <= '0;
			maxc_q <= '0;
			min_q  <= '0;
			minc_q <= '0;
		end else if (clr) begin
			sum_q  <= '0;
			max_q  <= '0;
			maxc_q <= '0;
			min_q  <= '0;
			minc_q <= '0;
		end else if (upd) begin
			sum_q <= sum_q + {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
			if (first || val > max_q) begin
				max_q  <= val;
				maxc_q <= STAT_CNT_W'(1);
			end else if (val == max_q && maxc_q != COUNT_CAP) begin
				maxc_q <= maxc_q + STAT_CNT_W'(1);
			end
			if (first || val < min_q) begin
				min_q  <= val;
				minc_q <= STAT_CNT_W'(1);
			end else if (val == min_q && minc_q != COUNT_CAP) begin
				minc_q <= minc_q + STAT_CNT_W'(1);
			end
		end
	end

	assign stats.sum     = sum_q;
	assign stats.max_val = max_q;
	assign stats.max_cnt = maxc_q;
	assign stats.min_val = min_q;
	assign stats.min_cnt = minc_q;
endmodule

// File: hdl/sort_with_extreme_counts_unit.sv
// Top level: load sequencer, histogram walk and output register.
// Depends on swec_pkg, swec_hist_ram, swec_stats and the assertion macro header.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid/in_stall   | digit_a, digit_b, digit_c, is_last
//  out     | out_valid/out_stall | sorted_value, last_result, value_sum, max_value,
//          |                     | max_count, min_value, min_count, overflow_flag
//
// Loading takes one item per cycle; each stored value bumps its bin in the histogram memory
// with a read-modify-write, forwarded when two neighbors hit the same bin.
// After the last item: a flush state, then a read state and a take state per bin visited
// (the memory read is registered) plus an emit state per result.
// Reset starts a clearing pass over all 64 histogram bins; input stalls meanwhile.
// Output stall holds the output register and pauses the walk; input stalls until the
// last result is registered.
`timescale 1ns / 1ps
module sort_with_extreme_counts_unit #(
	parameter int MAX_ITEMS = swec_pkg::MAX_ITEMS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [swec_pkg::DIG_W-1:0]             digit_a,
	input  logic [swec_pkg::DIG_W-1:0]             digit_b,
	input  logic [swec_pkg::DIG_W-1:0]             digit_c,
	input  logic                                   is_last,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [swec_pkg::VAL_W-1:0]      sorted_value,
	output logic                                   last_result,
	output logic signed [swec_pkg::SUM_W-1:0]      value_sum,
	output logic signed [swec_pkg::VAL_W-1:0]      max_value,
	output logic [swec_pkg::STAT_CNT_W-1:0]        max_count,
	output logic signed [swec_pkg::VAL_W-1:0]      min_value,
	output logic [swec_pkg::STAT_CNT_W-1:0]        min_count,
	output logic                                   overflow_flag
);
	import swec_pkg::*;
	`include "sort_with_extreme_counts_unit_macros.svh"

	localparam int HCNT_W = $clog2(MAX_ITEMS+1);

	swec_state_t state_q, state_d;

	logic [VAL_W-1:0]   idx_q;
	logic [HCNT_W-1:0]  rem_q;
	logic [HCNT_W-1:0]  emit_cnt_q;
	logic [HCNT_W-1:0]  item_cnt_q;
	logic               dropped_q;
	logic               ld_vld_s1;
	logic [VAL_W-1:0]   ld_addr_s1;
	logic               wr_vld_q;
	logic [VAL_W-1:0]   wr_addr_q;
	logic [HCNT_W-1:0]  wr_data_q;
	logic               out_vld_q;

	logic               rd_en, wr_en;
	logic [VAL_W-1:0]   rd_addr, wr_addr;
	logic [HCNT_W-1:0]  wr_data, rd_data, hist_inc;
	logic               accept, store, full, fwd;
	logic               emit_go, last_emit, rem_last, out_free;
	logic [VAL_W-1:0]   val_raw, bin_code;
	swec_stats_t        stats;

	assign accept    = in_valid && !in_stall;
	assign full      = item_cnt_q == HCNT_W'(MAX_ITEMS);
	assign store     = accept && !full;
	assign val_raw   = {{(VAL_W-DIG_W){1'b0}}, digit_a} + {{(VAL_W-DIG_W){1'b0}}, digit_b}
		- {{(VAL_W-DIG_W){1'b0}}, digit_c};
	// walk the bins in signed order: flip the sign bit of the index
	assign bin_code  = {~idx_q[VAL_W-1], idx_q[VAL_W-2:0]};
	assign fwd       = wr_vld_q && (wr_addr_q == ld_addr_s1);
	assign hist_inc  = (fwd ? wr_data_q : rd_data) + HCNT_W'(1);
	assign out_free  = !out_vld_q || !out_stall;
	assign last_emit = emit_cnt_q == (item_cnt_q - HCNT_W'(1));
	assign rem_last  = rem_q == HCNT_W'(1);

	swec_hist_ram #(.MAX_ITEMS(MAX_ITEMS)) u_hist (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	swec_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (store),
		.first  (item_cnt_q == '0),
		.clr    (emit_go && last_emit),
		.val    (signed'(val_raw)),
		.stats  (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = val_raw;
		wr_en    = ld_vld_s1;
		wr_addr  = ld_addr_s1;
		wr_data  = hist_inc;
		emit_go  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = '0;
				if (idx_q == '1) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				in_stall = 1'b0;
				rd_en    = store;
				if (accept && is_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// let the final bin update land before the walk reads it
				state_d = ST_READ;
			end
			ST_READ: begin
				rd_en   = 1'b1;
				rd_addr = bin_code;
				state_d = ST_TAKE;
			end
			ST_TAKE: begin
				// drain the bin: zero it for the next run
				wr_en   = 1'b1;
				wr_addr = bin_code;
				wr_data = '0;
				state_d = (rd_data == '0) ? ST_READ : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_go = 1'b1;
					if (last_emit) begin
						state_d = ST_LOAD;
					end else if (rem_last) begin
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			emit_cnt_q <= '0;
			item_cnt_q <= '0;
			dropped_q  <= 1'b0;
			ld_vld_s1  <= 1'b0;
			wr_vld_q   <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			ld_vld_s1 <= store;
			wr_vld_q  <= ld_vld_s1;
			if (state_q == ST_CLEAR) begin
				idx_q <= idx_q + VAL_W'(1);
			end else if (state_q == ST_TAKE && rd_data == '0) begin
				idx_q <= idx_q + VAL_W'(1);
			end else if (emit_go) begin
				if (last_emit) begin
					idx_q <= '0;
				end else if (rem_last) begin
					idx_q <= idx_q + VAL_W'(1);
				end
			end
			if (store) begin
				item_cnt_q <= item_cnt_q + HCNT_W'(1);
			end else if (emit_go && last_emit) begin
				item_cnt_q <= '0;
			end
			if (accept && full) begin
				dropped_q <= 1'b1;
			end else if (emit_go && last_emit) begin
				dropped_q <= 1'b0;
			end
			if (emit_go) begin
				emit_cnt_q <= last_emit ? '0 : emit_cnt_q + HCNT_W'(1);
			end
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ld_addr_s1 <= val_raw;
		wr_addr_q  <= ld_addr_s1;
		wr_data_q  <= hist_inc;
		if (state_q == ST_TAKE) begin
			rem_q <= rd_data;
		end else if (emit_go) begin
			rem_q <= rem_q - HCNT_W'(1);
		end
		if (emit_go) begin
			sorted_value  <= signed'(bin_code);
			last_result   <= last_emit;
			value_sum     <= stats.sum;
			max_value     <= stats.max_val;
			max_count     <= stats.max_cnt;
			min_value     <= stats.min_val;
			min_count     <= stats.min_cnt;
			overflow_flag <= dropped_q;
		end
	end

	assign out_valid = out_vld_q;

	`SWEC_ASSERT_NOW(a_emit_in_range, clk, arst_n, state_q == ST_EMIT, emit_cnt_q < item_cnt_q, "emit count passed item count")
	`SWEC_ASSERT_NOW(a_rem_nonzero, clk, arst_n, state_q == ST_EMIT, rem_q != '0, "emitting from an empty bin")
	`SWEC_ASSERT_NEXT(a_run_closed, clk, arst_n, emit_go && last_emit, state_q == ST_LOAD && item_cnt_q == '0, "run not closed after last result")
	`SWEC_ASSERT_NOW(a_walk_bounded, clk, arst_n, state_q == ST_TAKE && rd_data == '0, idx_q != '1, "histogram walk ran past the top bin")
endmodule
